@@ src/cpag_pkg.sv @@
// ----------------------------------------------------------------------------
// Chess piece attack generator package
// Shared types, board constants and line helpers for the attack pipeline.
// ----------------------------------------------------------------------------
package cpag_pkg;

	localparam logic [63:0] FILE_A_CLEAR = 64'hFEFE_FEFE_FEFE_FEFE;
	localparam logic [63:0] FILE_H_CLEAR = 64'h7F7F_7F7F_7F7F_7F7F;
	localparam logic [63:0] ALL_SQUARES  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] FILE_A_LINE  = 64'h0101_0101_0101_0101;
	localparam logic [63:0] RANK_1_LINE  = 64'h0000_0000_0000_00FF;
	localparam logic [63:0] MAIN_DIAG    = 64'h8040_2010_0804_0201;
	localparam logic [63:0] MAIN_ANTI    = 64'h0102_0408_1020_4080;

	typedef enum logic [2:0] {
		KIND_NONE   = 3'd0,
		KIND_KNIGHT = 3'd1,
		KIND_BISHOP = 3'd2,
		KIND_ROOK   = 3'd3,
		KIND_QUEEN  = 3'd4,
		KIND_KING   = 3'd5,
		KIND_ALL    = 3'd6,
		KIND_PAWN   = 3'd7
	} piece_kind_t;

	typedef struct packed {
		piece_kind_t piece_kind;
		logic [5:0]  square_index;
		logic [63:0] occupancy;
	} query_t;

	typedef struct packed {
		logic [63:0] attack_set;
		logic        unsupported_kind;
	} answer_t;

	typedef struct packed {
		logic s1;
		logic s2;
	} stage_en_t;

	function automatic logic [63:0] bit_rev(input logic [63:0] b);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) begin
			r[i] = b[63 - i];
		end
		return r;
	endfunction

	function automatic logic [63:0] go_e(input logic [63:0] b);
		return (b << 1) & FILE_A_CLEAR;
	endfunction

	function automatic logic [63:0] go_w(input logic [63:0] b);
		return (b >> 1) & FILE_H_CLEAR;
	endfunction

	function automatic logic [63:0] diag_line(input logic [5:0] sq);
		logic [2:0] rank;
		logic [2:0] file;
		logic [2:0] d;
		logic [63:0] m;
		rank = sq[5:3];
		file = sq[2:0];
		if (rank >= file) begin
			d = rank - file;
			m = MAIN_DIAG << {d, 3'b000};
		end else begin
			d = file - rank;
			m = MAIN_DIAG >> {d, 3'b000};
		end
		return m;
	endfunction

	function automatic logic [63:0] anti_line(input logic [5:0] sq);
		logic [3:0] sum;
		logic [2:0] d;
		logic [63:0] m;
		sum = {1'b0, sq[5:3]} + {1'b0, sq[2:0]};
		if (sum >= 4'd7) begin
			d = 3'(sum - 4'd7);
			m = MAIN_ANTI << {d, 3'b000};
		end else begin
			d = 3'(4'd7 - sum);
			m = MAIN_ANTI >> {d, 3'b000};
		end
		return m;
	endfunction

	function automatic logic [63:0] knight_set(input logic [5:0] sq);
		logic [63:0] b;
		logic [63:0] e;
		logic [63:0] w;
		logic [63:0] ee;
		logic [63:0] ww;
		b  = 64'd1 << sq;
		e  = go_e(b);
		w  = go_w(b);
		ee = go_e(e);
		ww = go_w(w);
		return (e << 16) | (ee << 8) | (ee >> 8) | (e >> 16) |
		       (w << 16) | (ww << 8) | (ww >> 8) | (w >> 16);
	endfunction

	function automatic logic [63:0] king_set(input logic [5:0] sq);
		logic [63:0] b;
		logic [63:0] e;
		logic [63:0] w;
		b = 64'd1 << sq;
		e = go_e(b);
		w = go_w(b);
		return (b << 8) | (b >> 8) | e | w |
		       (e << 8) | (e >> 8) | (w << 8) | (w >> 8);
	endfunction

endpackage

@@ src/cpag_line.sv @@
// ----------------------------------------------------------------------------
// Sliding line unit
// Two pipeline stages of the hyperbola quintessence for one line through the
// square: masking and reversal, then the forward and reversed subtractions.
// ----------------------------------------------------------------------------
module cpag_line (
	input  logic                clk,
	input  cpag_pkg::stage_en_t en,
	input  logic [5:0]          square_index,
	input  logic [63:0]         occupancy,
	input  logic [63:0]         line_mask,
	output logic [63:0]         line_attack
);
	import cpag_pkg::*;

	logic [63:0] occ_s1;
	logic [63:0] occ_rev_s1;
	logic [63:0] sq2_s1;
	logic [63:0] sq2_rev_s1;
	logic [63:0] mask_s1;
	logic [63:0] fwd_s2;
	logic [63:0] rev_s2;
	logic [63:0] mask_s2;
	logic [63:0] sq_bit;
	logic [63:0] occ_masked;

	assign sq_bit     = 64'd1 << square_index;
	assign occ_masked = occupancy & line_mask;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			occ_s1     <= occ_masked;
			occ_rev_s1 <= bit_rev(occ_masked);
			sq2_s1     <= sq_bit << 1;
			sq2_rev_s1 <= bit_rev(sq_bit) << 1;
			mask_s1    <= line_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			fwd_s2  <= occ_s1 - sq2_s1;
			rev_s2  <= occ_rev_s1 - sq2_rev_s1;
			mask_s2 <= mask_s1;
		end
	end

	assign line_attack = (fwd_s2 ^ bit_rev(rev_s2)) & mask_s2;

endmodule

@@ src/chess_piece_attack_generator_core.sv @@
// ----------------------------------------------------------------------------
// Chess piece attack generator core
// Computes the attack set of a piece on a square for a given occupancy.
// ----------------------------------------------------------------------------
// A query transaction carries a piece kind, a square and an occupancy board.
// Each query produces exactly one answer transaction with the attack set and
// a flag that is set when the unsupported pawn kind was requested.
// Both channels use valid and stall; a transaction completes at a rising edge
// where valid is high and stall is low.
// The pipeline has three register stages: line masking and reversal, the
// 64-bit subtractions of the sliding lines, and the final combine and kind
// select, which is also the answer register. A query's answer is presented
// from the answer register once the query has passed through the stages in
// order, and one query is accepted in every cycle while query stall is low.
// When the receiver stalls, the answer register holds, and earlier stages
// keep filling until each holds a query; a stage with no query never blocks
// the one before it. Query stall rises only when the first stage is full and
// cannot advance.
// Reset empties all stages; no answer is presented until queries arrive.
// ----------------------------------------------------------------------------
module chess_piece_attack_generator_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             query_valid,
	output logic             query_stall,
	input  cpag_pkg::query_t query,
	output logic             answer_valid,
	input  logic             answer_stall,
	output cpag_pkg::answer_t answer
);
	import cpag_pkg::*;

	logic        v_s1;
	logic        v_s2;
	logic        v_s3;
	logic        en1;
	logic        en2;
	logic        en3;
	stage_en_t   line_en;

	piece_kind_t kind_s1;
	piece_kind_t kind_s2;
	logic [63:0] leap_s1;
	logic [63:0] leap_s2;
	answer_t     answer_s3;

	logic [63:0] leap_next;
	logic [63:0] rank_sel;
	logic [63:0] file_sel;
	logic [63:0] diag_sel;
	logic [63:0] anti_sel;
	logic [63:0] rank_att;
	logic [63:0] file_att;
	logic [63:0] diag_att;
	logic [63:0] anti_att;
	logic [63:0] rook_att;
	logic [63:0] bishop_att;
	answer_t     answer_next;

	assign en3 = !v_s3 || !answer_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign query_stall = !en1;
	assign line_en = '{s1: en1, s2: en2};

	assign rank_sel = RANK_1_LINE << {query.square_index[5:3], 3'b000};
	assign file_sel = FILE_A_LINE << query.square_index[2:0];
	assign diag_sel = diag_line(query.square_index);
	assign anti_sel = anti_line(query.square_index);

	cpag_line u_rank (
		.clk(clk), .en(line_en), .square_index(query.square_index),
		.occupancy(query.occupancy), .line_mask(rank_sel), .line_attack(rank_att)
	);
	cpag_line u_file (
		.clk(clk), .en(line_en), .square_index(query.square_index),
		.occupancy(query.occupancy), .line_mask(file_sel), .line_attack(file_att)
	);
	cpag_line u_diag (
		.clk(clk), .en(line_en), .square_index(query.square_index),
		.occupancy(query.occupancy), .line_mask(diag_sel), .line_attack(diag_att)
	);
	cpag_line u_anti (
		.clk(clk), .en(line_en), .square_index(query.square_index),
		.occupancy(query.occupancy), .line_mask(anti_sel), .line_attack(anti_att)
	);

	always_comb begin
		unique case (query.piece_kind)
			KIND_KNIGHT: leap_next = knight_set(query.square_index);
			KIND_KING:   leap_next = king_set(query.square_index);
			default:     leap_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= query_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1 <= query.piece_kind;
			leap_s1 <= leap_next;
		end
		if (en2) begin
			kind_s2 <= kind_s1;
			leap_s2 <= leap_s1;
		end
		if (en3) begin
			answer_s3 <= answer_next;
		end
	end

	assign rook_att   = rank_att | file_att;
	assign bishop_att = diag_att | anti_att;

	always_comb begin
		answer_next = '{attack_set: '0, unsupported_kind: 1'b0};
		unique case (kind_s2)
			KIND_NONE:   answer_next.attack_set = '0;
			KIND_KNIGHT: answer_next.attack_set = leap_s2;
			KIND_BISHOP: answer_next.attack_set = bishop_att;
			KIND_ROOK:   answer_next.attack_set = rook_att;
			KIND_QUEEN:  answer_next.attack_set = rook_att | bishop_att;
			KIND_KING:   answer_next.attack_set = leap_s2;
			KIND_ALL:    answer_next.attack_set = ALL_SQUARES;
			KIND_PAWN:   answer_next.unsupported_kind = 1'b1;
			default:     answer_next.attack_set = '0;
		endcase
	end

	assign answer_valid = v_s3;
	assign answer       = answer_s3;

	a_pawn_empty: assert property (@(posedge clk) disable iff (!arst_n)
		answer_valid && answer.unsupported_kind |-> answer.attack_set == '0)
		else $error("unsupported kind answered with a nonzero attack set");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		query_stall |-> v_s1 && v_s2 && v_s3 && answer_stall)
		else $error("query stalled while the pipeline had room");

	a_answer_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(answer_valid) |-> $past(v_s2))
		else $error("answer appeared without a query in the second stage");

endmodule
